>>> hdl/mhih_pkg.sv
// shared types, codes and constants of the magnetometer hard-iron heading core
package mhih_pkg;

  typedef enum logic [2:0] {
    FN_CAL    = 3'd0,
    FN_FINISH = 3'd1,
    FN_HDG_XY = 3'd2,
    FN_HDG_XZ = 3'd3,
    FN_LOAD   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_RESULT,
    ST_BIAS
  } state_e;

  localparam int unsigned TAB_LEN = 24;
  localparam int unsigned TAB_W   = 22;
  // cordic datapath: 17-bit operands scaled by 256, plus room for gain
  localparam int unsigned XW      = 28;
  // angle accumulator, 2^24 units per turn
  localparam int unsigned AW      = 26;
  localparam int unsigned HW      = AW - 8;

  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(4194304);
  localparam logic signed [AW-1:0] ROUND_HALF   = AW'(128);

  typedef logic [$clog2(TAB_LEN)-1:0] tab_idx_t;
  typedef logic signed [16:0]         opnd_t;
  typedef logic signed [15:0]         axis_t;

  typedef struct packed {
    logic     load;
    logic     prerot;
    logic     iter;
    tab_idx_t idx;
  } cdc_ctrl_t;

  typedef struct packed {
    logic upd;
    logic load;
    logic finish;
  } cal_ctrl_t;

  function automatic logic [TAB_W-1:0] atan_tab(input tab_idx_t idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      5'd18:   v = 22'd10;
      5'd19:   v = 22'd5;
      5'd20:   v = 22'd3;
      5'd21:   v = 22'd1;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/mhih_intf.sv
// stream interfaces for sample requests and results
interface mhih_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, func, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, func, sample_x, sample_y, sample_z, output ready);
endinterface

interface mhih_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [16:0] heading;
  logic signed [15:0] bias_x_out;
  logic signed [15:0] bias_y_out;
  logic signed [15:0] bias_z_out;

  modport source (output valid, kind, heading, bias_x_out, bias_y_out, bias_z_out,
                  input ready);
  modport sink   (input valid, kind, heading, bias_x_out, bias_y_out, bias_z_out,
                  output ready);
endinterface

>>> hdl/mhih_calib.sv
// per-axis running min/max and hard-iron bias registers
module mhih_calib (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhih_pkg::cal_ctrl_t ctrl_i,
  input  mhih_pkg::axis_t     smp_x_i,
  input  mhih_pkg::axis_t     smp_y_i,
  input  mhih_pkg::axis_t     smp_z_i,
  output mhih_pkg::axis_t     bias_x_o,
  output mhih_pkg::axis_t     bias_y_o,
  output mhih_pkg::axis_t     bias_z_o,
  output mhih_pkg::axis_t     fin_x_o,
  output mhih_pkg::axis_t     fin_y_o,
  output mhih_pkg::axis_t     fin_z_o
);

  mhih_pkg::axis_t min_q [3];
  mhih_pkg::axis_t min_d [3];
  mhih_pkg::axis_t max_q [3];
  mhih_pkg::axis_t max_d [3];
  mhih_pkg::axis_t bias_q [3];
  mhih_pkg::axis_t bias_d [3];
  mhih_pkg::axis_t smp [3];
  mhih_pkg::axis_t fin [3];
  logic signed [16:0] sum [3];
  logic signed [16:0] sum_adj [3];

  assign smp[0] = smp_x_i;
  assign smp[1] = smp_y_i;
  assign smp[2] = smp_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]     = 17'(max_q[a]) + 17'(min_q[a]);
      // round toward zero before halving
      sum_adj[a] = sum[a] + 17'(sum[a][16]);
      fin[a]     = sum_adj[a][16:1];
      min_d[a]   = min_q[a];
      max_d[a]   = max_q[a];
      bias_d[a]  = bias_q[a];
      if (ctrl_i.upd) begin
        if (smp[a] < min_q[a]) min_d[a] = smp[a];
        if (smp[a] > max_q[a]) max_d[a] = smp[a];
      end
      if (ctrl_i.load) begin
        bias_d[a] = smp[a];
      end else if (ctrl_i.finish) begin
        bias_d[a] = fin[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a]  <= 16'sh7fff;
        max_q[a]  <= 16'sh8000;
        bias_q[a] <= '0;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        min_q[a]  <= min_d[a];
        max_q[a]  <= max_d[a];
        bias_q[a] <= bias_d[a];
      end
    end
  end

  assign bias_x_o = bias_q[0];
  assign bias_y_o = bias_q[1];
  assign bias_z_o = bias_q[2];
  assign fin_x_o  = fin[0];
  assign fin_y_o  = fin[1];
  assign fin_z_o  = fin[2];

endmodule

>>> hdl/mhih_cordic.sv
// shared cordic vectoring unit: one micro-rotation per step
module mhih_cordic (
  input  logic                        clk_i,
  input  mhih_pkg::cdc_ctrl_t         ctrl_i,
  input  mhih_pkg::opnd_t             x_i,
  input  mhih_pkg::opnd_t             y_i,
  output logic signed [mhih_pkg::AW-1:0] ang_o,
  output logic                        zero_o
);

  localparam int unsigned XW = mhih_pkg::XW;
  localparam int unsigned AW = mhih_pkg::AW;

  logic signed [XW-1:0] x_q, x_d;
  logic signed [XW-1:0] y_q, y_d;
  logic signed [AW-1:0] ang_q, ang_d;
  logic                 zero_q, zero_d;
  logic signed [XW-1:0] dx, dy;
  logic signed [AW-1:0] tab_ext;

  assign dx      = y_q >>> ctrl_i.idx;
  assign dy      = x_q >>> ctrl_i.idx;
  assign tab_ext = AW'(mhih_pkg::atan_tab(ctrl_i.idx));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    ang_d  = ang_q;
    zero_d = zero_q;
    if (ctrl_i.load) begin
      x_d    = {{(XW-25){x_i[16]}}, x_i, 8'b0};
      y_d    = {{(XW-25){y_i[16]}}, y_i, 8'b0};
      ang_d  = '0;
      zero_d = (x_i == '0) && (y_i == '0);
    end else if (ctrl_i.prerot) begin
      // turn a left-half vector by a quarter turn into the right half
      if (x_q < 0) begin
        if (y_q >= 0) begin
          x_d   = y_q;
          y_d   = -x_q;
          ang_d = mhih_pkg::QUARTER_TURN;
        end else begin
          x_d   = -y_q;
          y_d   = x_q;
          ang_d = -mhih_pkg::QUARTER_TURN;
        end
      end
    end else if (ctrl_i.iter) begin
      if (y_q >= 0) begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        ang_d = ang_q + tab_ext;
      end else begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        ang_d = ang_q - tab_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    zero_q <= zero_d;
  end

  assign ang_o  = ang_q;
  assign zero_o = zero_q;

endmodule

>>> hdl/magnetometer_hard_iron_heading_core.sv
// top level: sequencer, calibration store, cordic unit and result register
// Usage
//   in_i  : one request per transfer: func, sample_x, sample_y, sample_z.
//           func 0 folds the sample into the per-axis min/max, func 4 loads the
//           biases, func 1 finishes calibration, func 2/3 ask for a heading.
//   out_o : one result for func 1, 2 and 3; kind 1 carries biases, kind 0 a heading.
// Sequence
//   func 0 and 4 complete at the transfer; unused codes are dropped at the transfer.
//   func 1: the transfer, then the bias step registers the bias result.
//   func 2 and 3: the transfer latches the operands, the prep step does the
//   quarter-turn pre-rotation, CORDIC_STEPS iteration steps run the shared
//   add/shift unit, the result step rounds the angle into the output register.
//   in_i.ready is high only between requests.
// Reset
//   minima go to +32767, maxima to -32768, biases to zero; no result pending.
// Stall
//   the output register holds a result until taken; a new request is still
//   accepted, but its own result waits in the sequencer until the register frees.
module magnetometer_hard_iron_heading_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mhih_in_if.sink           in_i,
  mhih_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] LastStep = CntW'(CORDIC_STEPS - 1);
  localparam int unsigned AW = mhih_pkg::AW;
  localparam int unsigned HW = mhih_pkg::HW;

  mhih_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                xz_q, xz_d;
  logic                in_xfer;
  logic                slot_free;
  logic                out_load;
  logic                out_bias;
  mhih_pkg::cdc_ctrl_t cdc_ctrl;
  mhih_pkg::cal_ctrl_t cal_ctrl;
  mhih_pkg::opnd_t     op_x, op_y;
  mhih_pkg::axis_t     bias_x, bias_y, bias_z;
  mhih_pkg::axis_t     fin_x, fin_y, fin_z;
  logic signed [AW-1:0] ang;
  logic                ang_zero;
  logic signed [AW-1:0] ang_rnd;
  logic signed [HW-1:0] hdg_full;
  logic signed [16:0]  hdg;

  logic                out_valid_q;
  logic                out_kind_q;
  logic signed [16:0]  out_hdg_q;
  mhih_pkg::axis_t     out_bx_q, out_by_q, out_bz_q;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    xz_d    = xz_q;
    unique case (state_q)
      mhih_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.func) inside
            mhih_pkg::FN_FINISH: state_d = mhih_pkg::ST_BIAS;
            mhih_pkg::FN_HDG_XY, mhih_pkg::FN_HDG_XZ: begin
              state_d = mhih_pkg::ST_PREP;
              xz_d    = (in_i.func == mhih_pkg::FN_HDG_XZ);
            end
            default: state_d = mhih_pkg::ST_IDLE;
          endcase
        end
      end
      mhih_pkg::ST_PREP: begin
        state_d = mhih_pkg::ST_ITER;
        cnt_d   = '0;
      end
      mhih_pkg::ST_ITER: begin
        if (cnt_q == LastStep) begin
          state_d = mhih_pkg::ST_RESULT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mhih_pkg::ST_RESULT: begin
        if (slot_free) state_d = mhih_pkg::ST_IDLE;
      end
      mhih_pkg::ST_BIAS: begin
        if (slot_free) state_d = mhih_pkg::ST_IDLE;
      end
      default: state_d = mhih_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready      = 1'b0;
    cdc_ctrl        = '0;
    cdc_ctrl.idx    = mhih_pkg::tab_idx_t'(cnt_q);
    cal_ctrl        = '0;
    out_load        = 1'b0;
    out_bias        = 1'b0;
    unique case (state_q)
      mhih_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (in_i.func) inside
            mhih_pkg::FN_CAL:    cal_ctrl.upd  = 1'b1;
            mhih_pkg::FN_LOAD:   cal_ctrl.load = 1'b1;
            mhih_pkg::FN_HDG_XY, mhih_pkg::FN_HDG_XZ: cdc_ctrl.load = 1'b1;
            default: ;
          endcase
        end
      end
      mhih_pkg::ST_PREP:   cdc_ctrl.prerot = 1'b1;
      mhih_pkg::ST_ITER:   cdc_ctrl.iter   = 1'b1;
      mhih_pkg::ST_RESULT: out_load        = slot_free;
      mhih_pkg::ST_BIAS: begin
        out_load        = slot_free;
        out_bias        = 1'b1;
        cal_ctrl.finish = slot_free;
      end
      default: ;
    endcase
  end

  // operand selection at the request transfer
  always_comb begin
    if (in_i.func == mhih_pkg::FN_HDG_XZ) begin
      op_x = 17'(in_i.sample_x) - 17'(bias_x);
      op_y = 17'(in_i.sample_z) - 17'(bias_z);
    end else begin
      op_x = 17'(in_i.sample_x);
      op_y = 17'(in_i.sample_y);
    end
  end

  mhih_calib u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (cal_ctrl),
    .smp_x_i  (in_i.sample_x),
    .smp_y_i  (in_i.sample_y),
    .smp_z_i  (in_i.sample_z),
    .bias_x_o (bias_x),
    .bias_y_o (bias_y),
    .bias_z_o (bias_z),
    .fin_x_o  (fin_x),
    .fin_y_o  (fin_y),
    .fin_z_o  (fin_z)
  );

  mhih_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cdc_ctrl),
    .x_i    (op_x),
    .y_i    (op_y),
    .ang_o  (ang),
    .zero_o (ang_zero)
  );

  // round 2^24-per-turn angle to 2^16 units, xy wraps into one turn
  assign ang_rnd  = ang + mhih_pkg::ROUND_HALF;
  assign hdg_full = ang_rnd[AW-1:8];
  always_comb begin
    if (ang_zero) begin
      hdg = '0;
    end else if (xz_q) begin
      hdg = hdg_full[16:0];
    end else begin
      hdg = {1'b0, hdg_full[15:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhih_pkg::ST_IDLE;
      cnt_q       <= '0;
      xz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      xz_q    <= xz_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_bias;
      out_hdg_q  <= out_bias ? 17'sd0 : hdg;
      out_bx_q   <= out_bias ? fin_x : 16'sd0;
      out_by_q   <= out_bias ? fin_y : 16'sd0;
      out_bz_q   <= out_bias ? fin_z : 16'sd0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.heading    = out_hdg_q;
  assign out_o.bias_x_out = out_bx_q;
  assign out_o.bias_y_out = out_by_q;
  assign out_o.bias_z_out = out_bz_q;

  // a result only appears from the result or bias step of the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(state_q) == mhih_pkg::ST_RESULT || $past(state_q) == mhih_pkg::ST_BIAS))
    else $error("result raised outside a result step");

  // the step counter stays inside the table during iteration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mhih_pkg::ST_ITER |-> cnt_q <= LastStep)
    else $error("cordic step counter overran");

  // a request is only taken while the sequencer is idle, with no cordic pass or bias step in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> state_q == mhih_pkg::ST_IDLE)
    else $error("request transfer while busy");

  // bias results carry no heading, heading results carry no biases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_kind_q ? (out_hdg_q == '0)
                     : (out_bx_q == '0 && out_by_q == '0 && out_bz_q == '0)))
    else $error("result fields mixed between kinds");

endmodule
